### hdl/pnmhp_pkg.sv
// ----------------------------------------------------------------------------
// pnmhp_pkg
// Shared types and character codes for the binary PNM header parser.
// ----------------------------------------------------------------------------
package pnmhp_pkg;

	// Default accumulator width in bits (legal range 8 to 32)
	localparam int NUMBER_BITS_DEF = 31;

	// Width of every numeric result field
	localparam int FIELD_W = 31;

	// Character codes
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Parser phase
	typedef enum logic [3:0] {
		PH_START        = 4'd0,
		PH_LEAD_COMMENT = 4'd1,
		PH_TYPE         = 4'd2,
		PH_SKIP_W       = 4'd3,
		PH_NUM_W        = 4'd4,
		PH_SKIP_H       = 4'd5,
		PH_NUM_H        = 4'd6,
		PH_SKIP_M       = 4'd7,
		PH_NUM_M        = 4'd8
	} phase_t;

endpackage

### hdl/pnm_header_parser.sv
// ----------------------------------------------------------------------------
// pnm_header_parser
// Parses a binary PNM (P4/P5/P6) header one byte per item and delivers one
// result item per header: status, image kind, width, height, maxval and a
// saturation flag.
// ----------------------------------------------------------------------------
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle unless a result finds the output register full.
// The parser state updates once per byte.
// Reset: arst_n clears the parser state and both registers' valid flags;
//        after every result the parser returns to its reset state.
// ----------------------------------------------------------------------------
module pnm_header_parser #(
	parameter int NUMBER_BITS = pnmhp_pkg::NUMBER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_stream

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // [1:0] image_kind, [32:2] width,
	                                    // [63:33] height, [94:64] max_value,
	                                    // [95] saturated
	output logic        m_axis_tuser    // status
);

	import pnmhp_pkg::*;

	// Accumulator is capped at the result field width
	localparam int ACC_W = (NUMBER_BITS > FIELD_W) ? FIELD_W : NUMBER_BITS;
	localparam int MAC_W = ACC_W + 4;

	// Input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eos_s1;

	// Parser state
	phase_t           phase_q, phase_d;
	logic             in_comment_q, in_comment_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [ACC_W-1:0] width_val_q, width_val_d;
	logic [ACC_W-1:0] height_val_q, height_val_d;
	logic [1:0]       kind_q, kind_d;
	logic             ovf_q, ovf_d;

	// Result register
	logic             out_valid_q;
	logic             status_q;
	logic [1:0]       kind_out_q;
	logic [FIELD_W-1:0] width_out_q, height_out_q, max_out_q;
	logic             sat_out_q;

	// Step control
	logic             emit, emit_ok;
	logic             out_free, s1_fire;
	logic             is_digit;
	logic [3:0]       digit;
	logic [MAC_W-1:0] mac;
	logic             mac_sat;
	logic             skip_ok, skip_comment, skip_digit;
	logic             is_blank;

	// Result fields
	logic             res_status;
	logic [1:0]       res_kind;
	logic [FIELD_W-1:0] res_width, res_height, res_max;
	logic             res_sat;

	// Byte classification
	assign is_digit = !eos_s1 && (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign digit    = byte_s1[3:0];
	assign is_blank = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) || (byte_s1 == CH_LF);

	// Multiply-by-ten accumulate with saturation
	assign mac     = MAC_W'(acc_q) * MAC_W'(10) + MAC_W'(digit);
	assign mac_sat = |mac[MAC_W-1:ACC_W];

	// Separator and comment handling shared by the skip phases and the number ends
	always_comb begin
		skip_ok      = 1'b0;
		skip_comment = in_comment_q;
		skip_digit   = 1'b0;
		if (in_comment_q) begin
			skip_ok = !eos_s1;
			if (!eos_s1 && byte_s1 == CH_LF)
				skip_comment = 1'b0;
		end else if (!eos_s1) begin
			if (is_blank) begin
				skip_ok = 1'b1;
			end else if (byte_s1 == CH_HASH) begin
				skip_ok      = 1'b1;
				skip_comment = 1'b1;
			end else if (is_digit) begin
				skip_ok    = 1'b1;
				skip_digit = 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		phase_d      = phase_q;
		in_comment_d = in_comment_q;
		acc_d        = acc_q;
		width_val_d  = width_val_q;
		height_val_d = height_val_q;
		kind_d       = kind_q;
		ovf_d        = ovf_q;
		emit         = 1'b0;
		emit_ok      = 1'b0;

		unique case (phase_q)
			PH_LEAD_COMMENT: begin
				if (eos_s1 || byte_s1 == CH_LF)
					emit = 1'b1;
			end
			PH_TYPE: begin
				if (!eos_s1 && byte_s1 >= CH_4 && byte_s1 <= CH_6) begin
					kind_d  = 2'(byte_s1 - CH_4);
					phase_d = PH_SKIP_W;
				end else begin
					emit = 1'b1;
				end
			end
			PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
				in_comment_d = skip_comment;
				if (!skip_ok) begin
					emit = 1'b1;
				end else if (skip_digit) begin
					acc_d = ACC_W'(digit);
					case (phase_q)
						PH_SKIP_W: phase_d = PH_NUM_W;
						PH_SKIP_H: phase_d = PH_NUM_H;
						default:   phase_d = PH_NUM_M;
					endcase
				end
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
				if (is_digit) begin
					// Accumulate, clamp at the top value
					if (mac_sat) begin
						acc_d = '1;
						ovf_d = 1'b1;
					end else begin
						acc_d = mac[ACC_W-1:0];
					end
				end else if (phase_q == PH_NUM_W) begin
					width_val_d  = acc_q;
					acc_d        = '0;
					phase_d      = PH_SKIP_H;
					in_comment_d = skip_comment;
					emit         = !skip_ok;
				end else if (phase_q == PH_NUM_H) begin
					height_val_d = acc_q;
					if (kind_q == 2'd0) begin
						emit    = 1'b1;
						emit_ok = 1'b1;
					end else begin
						acc_d        = '0;
						phase_d      = PH_SKIP_M;
						in_comment_d = skip_comment;
						emit         = !skip_ok;
					end
				end else begin
					emit    = 1'b1;
					emit_ok = 1'b1;
				end
			end
			default: begin
				// First byte; unused codes behave the same
				if (!eos_s1 && byte_s1 == CH_HASH)
					phase_d = PH_LEAD_COMMENT;
				else if (!eos_s1 && byte_s1 == CH_P)
					phase_d = PH_TYPE;
				else
					emit = 1'b1;
			end
		endcase

		// Return to the reset state after any result
		if (emit) begin
			phase_d      = PH_START;
			in_comment_d = 1'b0;
			acc_d        = '0;
			width_val_d  = '0;
			height_val_d = '0;
			kind_d       = 2'd0;
			ovf_d        = 1'b0;
		end
	end

	// Result fields
	always_comb begin
		res_status = !emit_ok;
		res_kind   = 2'd0;
		res_width  = '0;
		res_height = '0;
		res_max    = '0;
		res_sat    = 1'b0;
		if (emit_ok) begin
			res_kind   = kind_q;
			res_width  = FIELD_W'(width_val_q);
			res_height = (phase_q == PH_NUM_H) ? FIELD_W'(acc_q) : FIELD_W'(height_val_q);
			res_max    = (phase_q == PH_NUM_M) ? FIELD_W'(acc_q) : '0;
			res_sat    = ovf_q;
		end
	end

	// Handshake: a byte advances unless its result finds the output full
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_fire       = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || s1_fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			in_comment_q <= 1'b0;
			acc_q        <= '0;
			width_val_q  <= '0;
			height_val_q <= '0;
			kind_q       <= 2'd0;
			ovf_q        <= 1'b0;
		end else if (s1_fire) begin
			phase_q      <= phase_d;
			in_comment_q <= in_comment_d;
			acc_q        <= acc_d;
			width_val_q  <= width_val_d;
			height_val_q <= height_val_d;
			kind_q       <= kind_d;
			ovf_q        <= ovf_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			status_q     <= res_status;
			kind_out_q   <= res_kind;
			width_out_q  <= res_width;
			height_out_q <= res_height;
			max_out_q    <= res_max;
			sat_out_q    <= res_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {sat_out_q, max_out_q, height_out_q, width_out_q, kind_out_q};

endmodule

### test/pnm_header_parser_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pnm_header_parser_checker
// Watches both streams of the PNM header parser, predicts the result item of
// every header from the accepted bytes and compares each one field by field.
// ----------------------------------------------------------------------------
module pnm_header_parser_checker #(
	parameter int NUMBER_BITS = pnmhp_pkg::NUMBER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,    // end_of_stream

	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,    // [1:0] image_kind, [32:2] width,
	                                // [63:33] height, [94:64] max_value,
	                                // [95] saturated
	input  logic        m_tuser,    // status

	output int          fail_count,
	output int          pending,
	output int          items_seen,
	output int          headers_ok,
	output int          headers_bad,
	output int          headers_sat
);

	import pnmhp_pkg::*;

	// Largest value a number may reach before it clamps
	localparam logic [63:0] ACC_MAX = (NUMBER_BITS >= 31) ? 64'h7FFF_FFFF :
	                                  ((64'd1 << NUMBER_BITS) - 64'd1);

	typedef struct packed {
		logic               status;
		logic [1:0]         kind;
		logic [FIELD_W-1:0] width;
		logic [FIELD_W-1:0] height;
		logic [FIELD_W-1:0] max_value;
		logic               saturated;
	} header_t;

	header_t expected_headers[$];
	header_t want;
	header_t got;

	// Shadow of the parser state
	phase_t             ph;
	logic               in_cmt;
	logic [FIELD_W-1:0] acc;
	logic [FIELD_W-1:0] wid;
	logic [FIELD_W-1:0] hgt;
	logic [1:0]         kind;
	logic               ovf;

	initial begin
		fail_count  = 0;
		pending     = 0;
		items_seen  = 0;
		headers_ok  = 0;
		headers_bad = 0;
		headers_sat = 0;
	end

	function automatic void clear_parser();
		ph     = PH_START;
		in_cmt = 1'b0;
		acc    = '0;
		wid    = '0;
		hgt    = '0;
		kind   = 2'd0;
		ovf    = 1'b0;
	endfunction

	// Queue the result of the current header and return to the idle state
	function automatic void finish_header(input logic ok);
		header_t h;
		h.status    = !ok;
		h.kind      = ok ? kind : 2'd0;
		h.width     = ok ? wid : '0;
		h.height    = ok ? hgt : '0;
		h.max_value = (ok && kind != 2'd0) ? acc : '0;
		h.saturated = ok ? ovf : 1'b0;
		expected_headers.push_back(h);
		if (ok) begin
			headers_ok++;
			if (ovf)
				headers_sat++;
		end else begin
			headers_bad++;
		end
		clear_parser();
	endfunction

	// Whitespace, comment or first digit ahead of a number; 0 on a bad byte
	function automatic logic skip_ok(input logic [7:0] b, input logic eos);
		if (in_cmt) begin
			if (eos)
				return 1'b0;
			if (b == CH_LF)
				in_cmt = 1'b0;
			return 1'b1;
		end
		if (eos)
			return 1'b0;
		if (b == CH_SPACE || b == CH_TAB || b == CH_LF)
			return 1'b1;
		if (b == CH_HASH) begin
			in_cmt = 1'b1;
			return 1'b1;
		end
		if (b >= CH_0 && b <= CH_9) begin
			acc = FIELD_W'(b - CH_0);
			ph  = phase_t'(ph + 4'd1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the shadow parser by one accepted item
	function automatic void parse_byte(input logic [7:0] b, input logic eos);
		logic        digit;
		logic [63:0] n;
		digit = !eos && b >= CH_0 && b <= CH_9;
		case (ph)
			PH_LEAD_COMMENT: begin
				if (eos || b == CH_LF)
					finish_header(1'b0);
			end
			PH_TYPE: begin
				if (!eos && b >= CH_4 && b <= CH_6) begin
					kind = 2'(b - CH_4);
					ph   = PH_SKIP_W;
				end else begin
					finish_header(1'b0);
				end
			end
			PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
				if (!skip_ok(b, eos))
					finish_header(1'b0);
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
				if (digit) begin
					n = 64'(acc) * 64'd10 + 64'(b - CH_0);
					if (n > ACC_MAX) begin
						n   = ACC_MAX;
						ovf = 1'b1;
					end
					acc = n[FIELD_W-1:0];
				end else if (ph == PH_NUM_W) begin
					wid = acc;
					acc = '0;
					ph  = PH_SKIP_H;
					if (!skip_ok(b, eos))
						finish_header(1'b0);
				end else if (ph == PH_NUM_H) begin
					hgt = acc;
					if (kind == 2'd0) begin
						finish_header(1'b1);
					end else begin
						acc = '0;
						ph  = PH_SKIP_M;
						if (!skip_ok(b, eos))
							finish_header(1'b0);
					end
				end else begin
					finish_header(1'b1);
				end
			end
			default: begin
				if (!eos && b == CH_HASH)
					ph = PH_LEAD_COMMENT;
				else if (!eos && b == CH_P)
					ph = PH_TYPE;
				else
					finish_header(1'b0);
			end
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [63:0] exp_v,
	                             input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d",
				$time, name, exp_v, act_v);
		end
	endtask

	// Check results first: a byte accepted at this edge cannot answer at it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_headers.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status    = m_tuser;
				got.kind      = m_tdata[1:0];
				got.width     = m_tdata[32:2];
				got.height    = m_tdata[63:33];
				got.max_value = m_tdata[94:64];
				got.saturated = m_tdata[95];
				if (expected_headers.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, %s",
						$time,
						$sformatf("actual status %0d kind %0d width %0d %s",
							got.status, got.kind, got.width,
							$sformatf("height %0d max %0d sat %0d",
								got.height, got.max_value, got.saturated)));
				end else begin
					want = expected_headers.pop_front();
					compare_field("status", 64'(want.status), 64'(got.status));
					compare_field("image_kind", 64'(want.kind), 64'(got.kind));
					compare_field("width", 64'(want.width), 64'(got.width));
					compare_field("height", 64'(want.height), 64'(got.height));
					compare_field("max_value", 64'(want.max_value),
						64'(got.max_value));
					compare_field("saturated", 64'(want.saturated),
						64'(got.saturated));
				end
			end
			if (s_tvalid && s_tready) begin
				items_seen++;
				parse_byte(s_tdata, s_tlast);
			end
			pending = expected_headers.size();
		end
	end

endmodule

### test/pnm_header_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pnm_header_parser_tb
// Feeds the PNM header parser with directed headers and then with random
// well-formed, truncated and corrupted headers and noise, under random idle
// bursts on both streams and one long output stall; the checker judges.
// ----------------------------------------------------------------------------
module pnm_header_parser_tb;

	import pnmhp_pkg::*;

	localparam int RANDOM_BYTES = 560;
	localparam int QUIET_FROM   = 460;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		HDR_CLEAN,
		HDR_TRUNCATED,
		HDR_CORRUPTED
	} hdr_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	int fail_count;
	int pending;
	int items_seen;
	int headers_ok;
	int headers_bad;
	int headers_sat;

	logic       idle_on = 1'b1;
	logic       hold_req = 1'b0;
	int         bytes_sent = 0;
	logic [7:0] hdr_bytes[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pnm_header_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	pnm_header_parser_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.s_tlast     (s_axis_tlast),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.items_seen  (items_seen),
		.headers_ok  (headers_ok),
		.headers_bad (headers_bad),
		.headers_sat (headers_sat)
	);

	// Offer one item, with an optional idle burst ahead of it
	task automatic send_item(input logic [7:0] b, input logic eos);
		if (idle_on && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_item(s[i], 1'b0);
	endtask

	// Append a space, tab, newline, space and newline, or a comment with random content
	function automatic void add_sep();
		int         n;
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: hdr_bytes.push_back(CH_SPACE);
			1: hdr_bytes.push_back(CH_TAB);
			2: hdr_bytes.push_back(CH_LF);
			3: begin
				hdr_bytes.push_back(CH_SPACE);
				hdr_bytes.push_back(CH_LF);
			end
			default: begin
				hdr_bytes.push_back(CH_HASH);
				n = $urandom_range(0, 6);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					hdr_bytes.push_back((c == CH_LF) ? CH_TAB : c);
				end
				hdr_bytes.push_back(CH_LF);
			end
		endcase
	endfunction

	// Append a decimal number: mostly small, some random or near the limit, some too long
	function automatic void add_number();
		int          r;
		logic [63:0] v;
		string       s;
		r = $urandom_range(0, 19);
		v = 64'd0;
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) hdr_bytes.push_back(CH_0);
		if (r < 14)
			v = 64'($urandom_range(0, 999));
		else if (r < 16)
			v = 64'($urandom()) & 64'h7FFF_FFFF;
		else if (r < 18)
			v = 64'h7FFF_FFFD + 64'($urandom_range(0, 3));
		if (r >= 18) begin
			hdr_bytes.push_back(8'(CH_0 + $urandom_range(1, 9)));
			repeat ($urandom_range(9, 12))
				hdr_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
		end else begin
			s = $sformatf("%0d", v);
			foreach (s[i])
				hdr_bytes.push_back(s[i]);
		end
	endfunction

	// Build a random header and send it clean, truncated or with one byte spoilt
	task automatic send_header(input hdr_mode_t mode);
		int         kind;
		int         nums;
		int         cut;
		logic [7:0] b;
		hdr_bytes.delete();
		kind = $urandom_range(0, 2);
		hdr_bytes.push_back(CH_P);
		hdr_bytes.push_back(8'(CH_4 + kind));
		if ($urandom_range(0, 5) != 0)
			add_sep();
		nums = (kind == 0) ? 2 : 3;
		for (int i = 0; i < nums; i++) begin
			if (i > 0) begin
				add_sep();
				if ($urandom_range(0, 3) == 0)
					add_sep();
			end
			add_number();
		end
		cut = hdr_bytes.size();
		if (mode == HDR_TRUNCATED)
			cut = $urandom_range(1, hdr_bytes.size() - 1);
		if (mode == HDR_CORRUPTED)
			hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		for (int i = 0; i < cut; i++)
			send_item(hdr_bytes[i], 1'b0);
		b = 8'($urandom_range(0, 255));
		if (mode == HDR_TRUNCATED || $urandom_range(0, 4) == 0) begin
			send_item(b, 1'b1);
		end else begin
			if (b >= CH_0 && b <= CH_9)
				b = CH_SPACE;
			send_item(b, 1'b0);
		end
	endtask

	// Output side: idle bursts, one long hold-off, steady ready at the end
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int r;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed headers and corner cases
		send_text("P4 1 1 ");
		send_text("P5 640 480 255\n");
		send_text("P6\t3\n# note\n2 65535 ");
		send_text("P512 7 9 ");                  // width straight after the type digit
		send_text("#x\n");                       // leading comment, always an error
		send_text("#");
		send_item(8'h00, 1'b1);                  // leading comment cut by end of stream
		send_text("P7");
		send_text("Q");
		send_item(8'hFF, 1'b1);                  // end of stream before anything
		send_text("P6 1 2 3");
		send_item(8'h5A, 1'b1);                  // last number ended by end of stream
		send_text("P4 5 6");
		send_item(8'hA5, 1'b1);
		send_text("P5 # c");
		send_item(8'h00, 1'b1);                  // end of stream inside a comment
		send_text("P5 99999999999 2147483647 2147483648 ");
		send_text("P5 0 0 0x");
		send_text("P5 1x");
		send_text("P");
		send_item(8'h00, 1'b1);
		send_text("P5");
		send_item(8'hFF, 1'b1);
		send_text("P4 1 2");
		send_item(8'hFF, 1'b0);
		send_text("P5 \t\n#\tall sorts\n 3 4 5 ");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("P6 1 1 2147483647 ");

		// Random part; stall the output early so the pipeline backs up
		hold_req = 1'b1;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= QUIET_FROM)
				idle_on = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 72)
				send_header(HDR_CLEAN);
			else if (r < 82)
				send_header(HDR_TRUNCATED);
			else if (r < 90)
				send_header(HDR_CORRUPTED);
			else
				send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end
		s_axis_tvalid <= 1'b0;

		// Drain
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d bytes with idle bursts and a %0d-cycle output stall.",
			items_seen, HOLD_CYCLES);
		$display("Headers seen: %0d accepted (%0d saturated), %0d malformed.",
			headers_ok, headers_sat, headers_bad);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/pnmhp_pkg.sv
hdl/pnm_header_parser.sv
test/pnm_header_parser_checker.sv
test/pnm_header_parser_tb.sv
